// ----- design/chgs_pkg.sv -----
package chgs_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CoordBits = 16;

  typedef enum logic [4:0] {
    StLoad,
    StMinRd,
    StMinCmp,
    StSwapRd,
    StSwapWr,
    StSortRd0,
    StSortRdA,
    StSortRdB,
    StSortRdC,
    StSortMul,
    StSortCmp,
    StSortSwap,
    StScanInit,
    StScanRdSt,
    StScanRdA,
    StScanRdB,
    StScanRdC,
    StScanMul,
    StScanCmp,
    StOutRd,
    StOutPt,
    StOutWait,
    StOutSend
  } state_e;

endpackage

// ----- design/chgs_ram.sv -----
module chgs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/chgs_turn.sv -----
module chgs_turn #(
  parameter int unsigned CoordBits = chgs_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic signed [CoordBits-1:0] ax_i,
  input  logic signed [CoordBits-1:0] ay_i,
  input  logic signed [CoordBits-1:0] bx_i,
  input  logic signed [CoordBits-1:0] by_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  output logic                        left_o,
  output logic                        right_o
);

  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [PW-1:0] p_q, q_q;

  assign d1x = DW'(bx_i) - DW'(ax_i);
  assign d1y = DW'(by_i) - DW'(ay_i);
  assign d2x = DW'(cx_i) - DW'(bx_i);
  assign d2y = DW'(cy_i) - DW'(by_i);

  always_ff @(posedge clk_i) begin
    p_q <= d1x * d2y;
    q_q <= d1y * d2x;
  end

  assign left_o  = p_q > q_q;
  assign right_o = p_q < q_q;

endmodule

// ----- design/convex_hull_graham_scan.sv -----
// Graham-scan convex hull. Points are loaded one per request (tdata = x, y)
// until tlast; up to MaxPoints are kept, further points are dropped and
// reported on every result as overflow. After the last point the block scans
// for the start point, insertion-sorts by cross-product sign (O(n^2) worst
// case), runs the stack scan and emits the hull counter-clockwise from the
// start point. The point and stack memories each have a single registered
// read port. No new set is accepted until the last vertex has been taken.
module convex_hull_graham_scan #(
  parameter int unsigned MaxPoints = chgs_pkg::MaxPoints,
  parameter int unsigned CoordBits = chgs_pkg::CoordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((2*CoordBits+7)/8)*8-1:0] s_axis_tdata,  // point_x, point_y
  input  logic        s_axis_tlast,                       // last_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((2*CoordBits+7)/8)*8-1:0] m_axis_tdata,  // hull_x, hull_y
  output logic        m_axis_tlast,                       // hull_last
  output logic        m_axis_tuser                        // overflow_seen
);

  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned PW = 2 * CoordBits;
  localparam int unsigned TW = ((2*CoordBits+7)/8)*8;

  chgs_pkg::state_e state_q, state_d;
  logic             start, busy;

  logic [CW-1:0] cnt_q, cnt_d, depth_q, depth_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [AW-1:0] k_q, k_d;
  logic          drop_q, drop_d;
  logic signed [CoordBits-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [CoordBits-1:0] ax_d, ay_d, bx_d, by_d, cx_d, cy_d;
  logic [AW-1:0] sa_q, sa_d, sb_q, sb_d;
  logic [TW-1:0] out_q, out_d;
  logic          olast_q, olast_d;

  logic          pwe, swe;
  logic [AW-1:0] pwa, pra, swa, sra, swd, srd;
  logic [PW-1:0] pwd, prd;
  logic signed [CoordBits-1:0] rx, ry;
  logic          left, right;

  assign rx = prd[CoordBits-1:0];
  assign ry = prd[PW-1:CoordBits];

  chgs_ram #(.Width(PW), .Depth(MaxPoints)) u_pts (
    .clk_i, .we_i(pwe), .waddr_i(pwa), .wdata_i(pwd), .raddr_i(pra), .rdata_o(prd)
  );

  chgs_ram #(.Width(AW), .Depth(MaxPoints)) u_stk (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd)
  );

  chgs_turn #(.CoordBits(CoordBits)) u_turn (
    .clk_i, .ax_i(ax_q), .ay_i(ay_q), .bx_i(bx_q), .by_i(by_q),
    .cx_i(cx_q), .cy_i(cy_q), .left_o(left), .right_o(right)
  );

  assign start = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign busy  = state_q != chgs_pkg::StLoad;

  assign s_axis_tready = !busy;
  assign m_axis_tvalid = state_q == chgs_pkg::StOutSend;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chgs_pkg::StLoad;
      cnt_q   <= '0;
      depth_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      depth_q <= depth_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d;
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    cx_q <= cx_d; cy_q <= cy_d; sa_q <= sa_d; sb_q <= sb_d;
    out_q <= out_d; olast_q <= olast_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; depth_d = depth_q; drop_d = drop_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q; cx_d = cx_q; cy_d = cy_q;
    sa_d = sa_q; sb_d = sb_q; out_d = out_q; olast_d = olast_q;
    pwe = 1'b0; pwa = cnt_q[AW-1:0]; pwd = s_axis_tdata[PW-1:0];
    pra = i_q[AW-1:0];
    swe = 1'b0; swa = depth_q[AW-1:0]; swd = i_q[AW-1:0];
    sra = '0;
    case (state_q)
      chgs_pkg::StLoad: begin
        if (s_axis_tvalid) begin
          if (cnt_q < CW'(MaxPoints)) begin
            pwe = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            i_d = '0;
            k_d = '0;
            state_d = chgs_pkg::StMinRd;
          end
        end
      end
      chgs_pkg::StMinRd: begin
        pra = i_q[AW-1:0];
        state_d = chgs_pkg::StMinCmp;
      end
      chgs_pkg::StMinCmp: begin
        if (i_q == '0 || rx < ax_q || (rx == ax_q && ry < ay_q)) begin
          ax_d = rx; ay_d = ry; k_d = i_q[AW-1:0];
        end
        if (i_q + 1'b1 < cnt_q) begin
          i_d = i_q + 1'b1;
          state_d = chgs_pkg::StMinRd;
        end else begin
          state_d = chgs_pkg::StSwapRd;
        end
      end
      chgs_pkg::StSwapRd: begin
        pra = '0;
        state_d = chgs_pkg::StSwapWr;
      end
      chgs_pkg::StSwapWr: begin
        // slot k takes old slot 0; slot 0 written in StSortRd0
        pwe = 1'b1; pwa = k_q; pwd = prd;
        i_d = CW'(2);
        state_d = chgs_pkg::StSortRd0;
      end
      chgs_pkg::StSortRd0: begin
        pwe = 1'b1; pwa = '0; pwd = {ay_q, ax_q};
        j_d = i_q;
        state_d = (i_q < cnt_q) ? chgs_pkg::StSortRdA : chgs_pkg::StScanInit;
      end
      chgs_pkg::StSortRdA: begin
        if (j_q > CW'(1)) begin
          pra = AW'(j_q - 1'b1);
          state_d = chgs_pkg::StSortRdB;
        end else begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
          state_d = (i_q + 1'b1 < cnt_q) ? chgs_pkg::StSortRdA : chgs_pkg::StScanInit;
        end
      end
      chgs_pkg::StSortRdB: begin
        bx_d = rx; by_d = ry;
        pra = j_q[AW-1:0];
        state_d = chgs_pkg::StSortRdC;
      end
      chgs_pkg::StSortRdC: begin
        cx_d = rx; cy_d = ry;
        state_d = chgs_pkg::StSortMul;
      end
      chgs_pkg::StSortMul: begin
        state_d = chgs_pkg::StSortCmp;
      end
      chgs_pkg::StSortCmp: begin
        if (right) begin
          // swap j and j-1: j now, j-1 in StSortSwap
          pwe = 1'b1; pwa = j_q[AW-1:0]; pwd = {by_q, bx_q};
          j_d = j_q - 1'b1;
          state_d = chgs_pkg::StSortSwap;
        end else begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
          state_d = (i_q + 1'b1 < cnt_q) ? chgs_pkg::StSortRdA : chgs_pkg::StScanInit;
        end
      end
      chgs_pkg::StSortSwap: begin
        pwe = 1'b1; pwa = j_q[AW-1:0]; pwd = {cy_q, cx_q};
        state_d = chgs_pkg::StSortRdA;
      end
      chgs_pkg::StScanInit: begin
        swe = cnt_q != '0; swa = '0; swd = '0;
        depth_d = (cnt_q > CW'(1)) ? CW'(2) : cnt_q;
        i_d = CW'(2);
        sb_d = AW'(1);
        state_d = (cnt_q > CW'(1)) ? chgs_pkg::StScanRdSt : chgs_pkg::StOutRd;
        if (cnt_q > CW'(1)) begin
          sa_d = '0;
        end
        k_d = '0;
      end
      chgs_pkg::StScanRdSt: begin
        if (depth_q == CW'(2) && sb_q == AW'(1)) begin
          swe = 1'b1; swa = AW'(1); swd = AW'(1);
        end
        if (i_q < cnt_q) begin
          sra = AW'(depth_q - CW'(2));
          pra = sb_q;
          state_d = chgs_pkg::StScanRdA;
        end else begin
          k_d = '0;
          state_d = chgs_pkg::StOutRd;
        end
      end
      chgs_pkg::StScanRdA: begin
        bx_d = rx; by_d = ry;
        sa_d = srd;
        pra = srd;
        state_d = chgs_pkg::StScanRdB;
      end
      chgs_pkg::StScanRdB: begin
        ax_d = rx; ay_d = ry;
        pra = i_q[AW-1:0];
        state_d = chgs_pkg::StScanRdC;
      end
      chgs_pkg::StScanRdC: begin
        cx_d = rx; cy_d = ry;
        state_d = chgs_pkg::StScanMul;
      end
      chgs_pkg::StScanMul: begin
        state_d = chgs_pkg::StScanCmp;
      end
      chgs_pkg::StScanCmp: begin
        if (left || depth_q < CW'(3)) begin
          swe = 1'b1;
          swa = left ? depth_q[AW-1:0] : AW'(depth_q - 1'b1);
          swd = i_q[AW-1:0];
          depth_d = left ? depth_q + 1'b1 : depth_q;
          sb_d = i_q[AW-1:0];
          i_d = i_q + 1'b1;
        end else begin
          depth_d = depth_q - 1'b1;
          sb_d = sa_q;
        end
        state_d = chgs_pkg::StScanRdSt;
      end
      chgs_pkg::StOutRd: begin
        sra = k_q;
        state_d = chgs_pkg::StOutPt;
      end
      chgs_pkg::StOutPt: begin
        pra = srd;
        olast_d = CW'(k_q) + 1'b1 == depth_q;
        state_d = chgs_pkg::StOutWait;
      end
      chgs_pkg::StOutWait: begin
        out_d = TW'(prd);
        state_d = chgs_pkg::StOutSend;
      end
      chgs_pkg::StOutSend: begin
        if (m_axis_tready) begin
          if (olast_q) begin
            cnt_d = '0; depth_d = '0; drop_d = 1'b0;
            state_d = chgs_pkg::StLoad;
          end else begin
            k_d = k_q + 1'b1;
            state_d = chgs_pkg::StOutRd;
          end
        end
      end
      default: state_d = chgs_pkg::StLoad;
    endcase
  end

  // depth 1 (single point): scan writes slot 0 only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> depth_q != '0)
    else $error("output with empty stack");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxPoints))
    else $error("count overflow");

endmodule

// ----- tb/convex_hull_graham_scan_test.sv -----
module convex_hull_graham_scan_test;

  localparam int unsigned Cap = chgs_pkg::MaxPoints;
  localparam int unsigned WatchLimit = 200000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               ovf;
  } vertex_t;

  class hull_scoreboard;
    logic signed [15:0] px[$];
    logic signed [15:0] py[$];
    bit dropped;
    vertex_t pending[$];
    int errors;
    int hulls;

    function int turn(int a, int b, int c);
      longint p, q;
      p = (longint'(px[b]) - px[a]) * (longint'(py[c]) - py[b]);
      q = (longint'(py[b]) - py[a]) * (longint'(px[c]) - px[b]);
      return p > q ? 1 : (p < q ? -1 : 0);
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      logic signed [15:0] t;
      int n, s, i, j, d, a, b;
      int stk[$];
      vertex_t v;
      if (px.size() < Cap) begin
        px = {px, x};
        py = {py, y};
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      n = px.size();
      s = 0;
      for (i = 1; i < n; i++)
        if (px[i] < px[s] || (px[i] == px[s] && py[i] < py[s])) s = i;
      t = px[0]; px[0] = px[s]; px[s] = t;
      t = py[0]; py[0] = py[s]; py[s] = t;
      for (i = 2; i < n; i++) begin
        j = i;
        while (j > 1 && turn(0, j - 1, j) < 0) begin
          t = px[j]; px[j] = px[j-1]; px[j-1] = t;
          t = py[j]; py[j] = py[j-1]; py[j-1] = t;
          j--;
        end
      end
      for (i = 0; i < n && i < 2; i++) stk = {stk, i};
      i = 2;
      while (i < n) begin
        d = stk.size();
        b = stk.pop_back();
        a = stk[d-2];
        if (turn(a, b, i) > 0) begin
          stk = {stk, b, i};
          i++;
        end else if (d < 3) begin
          stk = {stk, i};
          i++;
        end
      end
      foreach (stk[k]) begin
        v.x = px[stk[k]];
        v.y = py[stk[k]];
        v.last = (k == stk.size() - 1);
        v.ovf = dropped;
        pending = {pending, v};
      end
      hulls++;
      px.delete();
      py.delete();
      dropped = 1'b0;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("unexpected hull vertex x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin $error("hull_x exp %0d got %0d", e.x, got.x); errors++; end
      if (got.y !== e.y) begin $error("hull_y exp %0d got %0d", e.y, got.y); errors++; end
      if (got.last !== e.last) begin
        $error("hull_last exp %0d got %0d", e.last, got.last); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow_seen exp %0d got %0d", e.ovf, got.ovf); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  hull_scoreboard hulls_sb;
  int idle_pct_in = 30;
  int idle_pct_out = 30;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  int points_sent = 0;
  int vertices_seen = 0;

  convex_hull_graham_scan dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // returns at the accepting rising edge with tvalid still high
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    @(negedge clk_i);
    while (idle_pct_in > 0 && $urandom_range(99, 0) < idle_pct_in) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    hulls_sb.note_point(x, y, last);
    points_sent++;
  endtask

  task automatic send_set(int n, int span);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (span >= 32767) begin
        x = 16'($urandom); y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(2 * span, 0) - span);
        y = 16'($urandom_range(2 * span, 0) - span);
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (hulls_sb.pending.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      vertex_t v;
      v.x = m_axis_tdata[15:0];
      v.y = m_axis_tdata[31:16];
      v.last = m_axis_tlast;
      v.ovf = m_axis_tuser;
      hulls_sb.check_vertex(v);
      vertices_seen++;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && !(idle_pct_out > 0 && $urandom_range(99, 0) < idle_pct_out);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    hulls_sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // single point, two points, extremes
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
    // square with extremes and interior point
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    // collinear with repeats
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(-16'sd5, -16'sd5, 1'b1);
    // tie on x, and all same point
    send_point(16'sd3, 16'sd1, 1'b0);
    send_point(16'sd3, -16'sd1, 1'b0);
    send_point(16'sd4, 16'sd0, 1'b1);
    send_point(16'sd7, 16'sd7, 1'b0);
    send_point(16'sd7, 16'sd7, 1'b1);
    wait_drained();
    // overflow: full store plus drops, last item dropped
    send_set(Cap + 3, 32767);
    wait_drained();
    // receiver held off while sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_set(6, 50);
        send_set(5, 50);
      end
    join
    wait_drained();
    // no idling stretch
    idle_pct_in = 0;
    idle_pct_out = 0;
    repeat (4) send_set($urandom_range(8, 3), 1000);
    idle_pct_in = 30;
    idle_pct_out = 30;
    while (points_sent < 130) begin
      case ($urandom_range(3, 0))
        0: send_set($urandom_range(3, 1), 32767);
        1: send_set($urandom_range(12, 3), 8);
        default: send_set($urandom_range(12, 3), 32767);
      endcase
    end
    wait_drained();
    repeat (100) @(negedge clk_i);
    $display("Covered %0d points in %0d sets, %0d hull vertices checked.",
             points_sent, hulls_sb.hulls, vertices_seen);
    if (hulls_sb.errors == 0 && hulls_sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/chgs_pkg.sv
design/chgs_ram.sv
design/chgs_turn.sv
design/convex_hull_graham_scan.sv
tb/convex_hull_graham_scan_test.sv
